### sv/dda_pkg.sv
// Shared types and constants for the DDA line rasterizer.
`timescale 1ns / 1ps

package dda_pkg;

   // Input beat function codes.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // Controller states.
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_DIVIDE
   } dda_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture endpoints and set up the dividers
      logic div_step;  // one quotient bit for both axes
      logic emit;      // output one pixel and advance the accumulators
   } dda_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic steps_zero;  // no pixels left in the current line
      logic div_last;    // the current divide iteration is the final one
   } dda_status_type;

endpackage

### sv/dda_ctrl.sv
// Controller state machine for the DDA line rasterizer.
`timescale 1ns / 1ps

module dda_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output dda_pkg::dda_cmd_type    cmd,
   input  dda_pkg::dda_status_type status
);
   import dda_pkg::*;

   dda_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          out_blocked;

   // The output register blocks new beats only while its beat is held.
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = (state_ff == ST_DIVIDE) || out_blocked;
   assign accept      = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;

   // State and output-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_START) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end else if (accept && req_func == FUNC_STEP && !status.steps_zero) begin
               cmd.emit = 1'b1;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.emit || out_blocked;
   end

   // A start beat always leads into the divide phase.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DIVIDE)
      else $error("start beat did not enter the divide phase");

   // An emitted pixel is presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted pixel not presented");

   // No pixel is emitted while the increments are being divided.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> !cmd.emit && req_stall)
      else $error("pixel emitted or beat accepted during divide");

endmodule

### sv/dda_datapath.sv
// Datapath for the DDA line rasterizer: dividers, accumulators and output register.
`timescale 1ns / 1ps

module dda_datapath #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dda_pkg::dda_cmd_type    cmd,
   output dda_pkg::dda_status_type status,
   input  logic [COORD_BITS-1:0]   req_x_start,
   input  logic [COORD_BITS-1:0]   req_y_start,
   input  logic [COORD_BITS-1:0]   req_x_end,
   input  logic [COORD_BITS-1:0]   req_y_end,
   output logic [COORD_BITS-1:0]   rsp_pixel_x,
   output logic [COORD_BITS-1:0]   rsp_pixel_y,
   output logic                    rsp_last_pixel
);
   import dda_pkg::*;

   localparam int ACC_W = COORD_BITS + FRAC_BITS;
   localparam int Q_W   = FRAC_BITS + 1;
   localparam int REM_W = COORD_BITS + 1;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic [ACC_W-1:0]      x_accum_ff, x_accum_in;
   logic [ACC_W-1:0]      y_accum_ff, y_accum_in;
   logic [Q_W-1:0]        x_quot_ff, x_quot_in;
   logic [Q_W-1:0]        y_quot_ff, y_quot_in;
   logic [REM_W-1:0]      x_rem_ff, x_rem_in;
   logic [REM_W-1:0]      y_rem_ff, y_rem_in;
   logic                  x_neg_ff, x_neg_in;
   logic                  y_neg_ff, y_neg_in;
   logic [COORD_BITS-1:0] len_ff, len_in;
   logic [COORD_BITS-1:0] steps_ff, steps_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] pix_x_ff, pix_x_in;
   logic [COORD_BITS-1:0] pix_y_ff, pix_y_in;
   logic                  last_ff, last_in;

   logic [COORD_BITS:0]   x_diff, y_diff;
   logic [COORD_BITS:0]   x_mag, y_mag;
   logic [REM_W-1:0]      x_shift, y_shift;
   logic [REM_W:0]        x_trial, y_trial;
   logic                  first_iter;
   logic [ACC_W-1:0]      x_step, y_step;
   logic [ACC_W-1:0]      x_init, y_init;
   logic [ACC_W-1:0]      half;

   // Endpoint differences and their magnitudes.
   always_comb begin
      x_diff = {1'b0, req_x_end} - {1'b0, req_x_start};
      y_diff = {1'b0, req_y_end} - {1'b0, req_y_start};
      x_mag  = x_diff[COORD_BITS] ? -x_diff : x_diff;
      y_mag  = y_diff[COORD_BITS] ? -y_diff : y_diff;
   end

   // Start points: coordinate plus one half when the coordinate is non-zero.
   assign half   = ACC_W'(1) << (FRAC_BITS - 1);
   assign x_init = ({req_x_start, {FRAC_BITS{1'b0}}})
                   | ((req_x_start != '0) ? half : '0);
   assign y_init = ({req_y_start, {FRAC_BITS{1'b0}}})
                   | ((req_y_start != '0) ? half : '0);

   // One restoring divide iteration per axis; the first one does not shift.
   assign first_iter = (cnt_ff == '0);
   always_comb begin
      x_shift = first_iter ? x_rem_ff : {x_rem_ff[REM_W-2:0], 1'b0};
      y_shift = first_iter ? y_rem_ff : {y_rem_ff[REM_W-2:0], 1'b0};
      x_trial = {1'b0, x_shift} - {2'b00, len_ff};
      y_trial = {1'b0, y_shift} - {2'b00, len_ff};
   end

   // Signed increments applied as one's complement plus carry.
   assign x_step = ACC_W'(x_quot_ff) ^ {ACC_W{x_neg_ff}};
   assign y_step = ACC_W'(y_quot_ff) ^ {ACC_W{y_neg_ff}};

   // Next values of all datapath registers.
   always_comb begin
      x_accum_in = x_accum_ff;
      y_accum_in = y_accum_ff;
      x_quot_in  = x_quot_ff;
      y_quot_in  = y_quot_ff;
      x_rem_in   = x_rem_ff;
      y_rem_in   = y_rem_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      len_in     = len_ff;
      steps_in   = steps_ff;
      cnt_in     = cnt_ff;
      pix_x_in   = pix_x_ff;
      pix_y_in   = pix_y_ff;
      last_in    = last_ff;
      if (cmd.load) begin
         x_accum_in = x_init;
         y_accum_in = y_init;
         x_neg_in   = x_diff[COORD_BITS];
         y_neg_in   = y_diff[COORD_BITS];
         x_rem_in   = x_mag;
         y_rem_in   = y_mag;
         len_in     = (x_mag >= y_mag) ? x_mag[COORD_BITS-1:0] : y_mag[COORD_BITS-1:0];
         steps_in   = len_in;
         x_quot_in  = '0;
         y_quot_in  = '0;
         cnt_in     = '0;
      end else if (cmd.div_step) begin
         x_rem_in  = x_trial[REM_W] ? x_shift : x_trial[REM_W-1:0];
         y_rem_in  = y_trial[REM_W] ? y_shift : y_trial[REM_W-1:0];
         x_quot_in = {x_quot_ff[Q_W-2:0], !x_trial[REM_W]};
         y_quot_in = {y_quot_ff[Q_W-2:0], !y_trial[REM_W]};
         cnt_in    = cnt_ff + CNT_W'(1);
      end else if (cmd.emit) begin
         pix_x_in   = x_accum_ff[ACC_W-1:FRAC_BITS];
         pix_y_in   = y_accum_ff[ACC_W-1:FRAC_BITS];
         last_in    = (steps_ff == COORD_BITS'(1));
         x_accum_in = x_accum_ff + x_step + ACC_W'(x_neg_ff);
         y_accum_in = y_accum_ff + y_step + ACC_W'(y_neg_ff);
         steps_in   = steps_ff - COORD_BITS'(1);
      end
   end

   // Line state; the step count marks an active line and is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         steps_ff <= steps_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      x_accum_ff <= x_accum_in;
      y_accum_ff <= y_accum_in;
      x_quot_ff  <= x_quot_in;
      y_quot_ff  <= y_quot_in;
      x_rem_ff   <= x_rem_in;
      y_rem_ff   <= y_rem_in;
      x_neg_ff   <= x_neg_in;
      y_neg_ff   <= y_neg_in;
      len_ff     <= len_in;
      pix_x_ff   <= pix_x_in;
      pix_y_ff   <= pix_y_in;
      last_ff    <= last_in;
   end

   assign status.steps_zero = (steps_ff == '0);
   assign status.div_last   = (cnt_ff == CNT_W'(FRAC_BITS));

   assign rsp_pixel_x    = pix_x_ff;
   assign rsp_pixel_y    = pix_y_ff;
   assign rsp_last_pixel = last_ff;

endmodule

### sv/dda_line_rasterizer_top.sv
// Top level of the DDA line rasterizer: controller and datapath.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   func, x_start, y_start, x_end, y_end
//  rsp      out        rsp_valid/rsp_stall   pixel_x, pixel_y, last_pixel
//
// Pixels stream at one per cycle on step beats unless a held result blocks the output.
// During a start beat the restoring divider for the increments produces one
// quotient bit per cycle for both axes at once.
// Reset is synchronous and leaves the block idle with no line active.
// Input is stalled during the divide and while a held result fills the output register.
module dda_line_rasterizer_top #(
   parameter int COORD_BITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_last_pixel
);
   import dda_pkg::*;

   dda_cmd_type    cmd;
   dda_status_type status;

   // Sequencing of beats and divide iterations.
   dda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and storage.
   dda_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule
